FILE: hw/rtl/ihex_pkg.sv
// Shared types, constants and helpers for the HEX record decoder.
// Used by the front, queue, back and top modules under hw/rtl; has no dependencies of its own.
`default_nettype none

package ihex_pkg;

  // Element store sizing.
  localparam int MAX_ELEMENTS = 512;
  localparam int ROW_WIDTH    = 8;
  localparam int STORE_DEPTH  = 512;
  localparam int CAPACITY     = (MAX_ELEMENTS > STORE_DEPTH) ? STORE_DEPTH : MAX_ELEMENTS;
  localparam int HEADER_ELEMS = 7;

  localparam int BYTE_W       = 8;
  localparam int CHAR_IDX_W   = 11;
  localparam int POS_W        = 11;
  localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
  localparam int LANE_W       = $clog2(ROW_WIDTH);
  localparam int ROW_ADDR_W   = $clog2(STORE_DEPTH / ROW_WIDTH);
  localparam int RAM_DEPTH    = 2 * (STORE_DEPTH / ROW_WIDTH);
  localparam int RAM_ADDR_W   = ROW_ADDR_W + 1;
  localparam int ROW_CNT_W    = 4;

  // Segment arithmetic.
  localparam int SEG_W        = 20;
  localparam int ADDR_SUM_W   = 21;
  localparam logic [BYTE_W-1:0] SEG_TYPE = 8'd2;

  // Descriptor queue between front and back.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_IDX_W-1:0] CHAR_IDX_MAX = {CHAR_IDX_W{1'b1}};

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] elem0;
    logic [7:0] elem1;
    logic [7:0] elem2;
    logic [7:0] elem3;
    logic [7:0] elem4;
    logic [7:0] elem5;
    logic [7:0] elem6;
    logic [7:0] elem7;
    logic [3:0] row_count;
    logic       last_row;
    logic       bad_length;
  } out_item_t;

  typedef logic [ROW_WIDTH-1:0][BYTE_W-1:0] row_t;
  localparam int ROW_BITS = $bits(row_t);

  // One finished line, as handed from front to back.
  typedef struct packed {
    logic                  bad;
    logic [CNT_W-1:0]      cnt;
    logic                  bank;
    logic                  adj_en;
    logic [ADDR_SUM_W-1:0] adj;
  } desc_t;

  // Row write into the element RAM.
  typedef struct packed {
    logic                  en;
    logic [RAM_ADDR_W-1:0] addr;
    row_t                  data;
  } ram_wr_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decode one ASCII hex digit; ok is low for anything else.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      h.ok = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      h.ok = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      h.ok = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ihex_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ihex_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ihex_front.sv
// Front end: takes characters, pairs hex digits into bytes, packs rows into the
// element RAM and closes each line with a descriptor. Depends on ihex_pkg.
`default_nettype none

module ihex_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output      logic                        in_full,
  input  wire ihex_pkg::in_item_t          in_item,
  input  wire logic [ihex_pkg::QCNT_W-1:0] q_count,
  output      logic                        q_push,
  output      ihex_pkg::desc_t             q_desc,
  output      ihex_pkg::ram_wr_t           ram_wr
);

  logic [ihex_pkg::CHAR_IDX_W-1:0] k_r;
  logic [3:0]                      hi_r;
  logic                            pbad_r;
  logic                            ovf_r;
  logic [ihex_pkg::CNT_W-1:0]      cnt_r;
  ihex_pkg::row_t                  row_r;
  ihex_pkg::row_t                  row_nxt;
  logic [7:0]                      h4_r, h5_r, h6_r, h7_r, h8_r;
  logic                            fin_r;
  logic                            fin_bad_r;
  logic [ihex_pkg::SEG_W-1:0]      seg_base_r;
  logic                            seg_act_r;
  logic                            bank_r;

  logic                            accept;
  ihex_pkg::hex_t                  hx;
  logic [7:0]                      byte_val;
  logic [7:0]                      wr_val;
  logic                            wr_any;
  logic                            hdr3;
  logic [ihex_pkg::POS_W-1:0]      pos;
  logic [ihex_pkg::POS_W-1:0]      last_pos;
  logic                            in_cap;
  logic                            do_wr;
  logic [ihex_pkg::LANE_W-1:0]     lane;
  logic [ihex_pkg::CNT_W-1:0]      cnt_m1;
  logic [7:0]                      e4, e5, e6, e7, e8;
  logic                            is_seg;
  logic [ihex_pkg::ADDR_SUM_W-1:0] addr_sum;

  // The front stalls while it closes a line or when both RAM banks are taken.
  assign in_full = fin_r | (q_count == ihex_pkg::QCNT_W'(ihex_pkg::QUEUE_DEPTH));
  assign accept  = in_push & ~in_full;

  // Character classification and element placement.
  always_comb begin
    hx       = ihex_pkg::hex_decode(in_item.char_code);
    byte_val = (pbad_r | ~hx.ok) ? 8'd0 : {hi_r, hx.val};
    wr_any   = 1'b0;
    hdr3     = 1'b0;
    pos      = '0;
    wr_val   = '0;
    if (k_r == '0) begin
      wr_any = 1'b1;
      wr_val = in_item.char_code;
    end else if (!k_r[0]) begin
      wr_any = 1'b1;
      wr_val = byte_val;
      if (k_r[ihex_pkg::CHAR_IDX_W-1:1] == 10'd1) begin
        hdr3 = 1'b1;
        pos  = ihex_pkg::POS_W'(1);
      end else begin
        pos = ihex_pkg::POS_W'(k_r[ihex_pkg::CHAR_IDX_W-1:1]) + ihex_pkg::POS_W'(2);
      end
    end
    last_pos = hdr3 ? ihex_pkg::POS_W'(3) : pos;
    in_cap   = last_pos < ihex_pkg::POS_W'(ihex_pkg::CAPACITY);
    do_wr    = accept & wr_any & in_cap;
    lane     = pos[ihex_pkg::LANE_W-1:0];
  end

  // Row assembly; the length byte also places the two zero pads.
  always_comb begin
    row_nxt = row_r;
    if (do_wr) begin
      row_nxt[lane] = wr_val;
      if (hdr3) begin
        row_nxt[2] = 8'd0;
        row_nxt[3] = 8'd0;
      end
    end
  end

  // A row goes to RAM when its last lane fills, or partly filled at line end.
  always_comb begin
    cnt_m1      = cnt_r - ihex_pkg::CNT_W'(1);
    ram_wr.en   = 1'b0;
    ram_wr.addr = {bank_r, pos[ihex_pkg::LANE_W +: ihex_pkg::ROW_ADDR_W]};
    ram_wr.data = row_nxt;
    if (do_wr && lane == ihex_pkg::LANE_W'(ihex_pkg::ROW_WIDTH - 1)) begin
      ram_wr.en = 1'b1;
    end else if (fin_r && !fin_bad_r && cnt_r[ihex_pkg::LANE_W-1:0] != '0) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = {bank_r, cnt_m1[ihex_pkg::LANE_W +: ihex_pkg::ROW_ADDR_W]};
      ram_wr.data = row_r;
    end
  end

  // Header fields for the segment logic; elements not yet stored read as zero.
  always_comb begin
    e4       = (cnt_r > ihex_pkg::CNT_W'(4)) ? h4_r : 8'd0;
    e5       = (cnt_r > ihex_pkg::CNT_W'(5)) ? h5_r : 8'd0;
    e6       = (cnt_r > ihex_pkg::CNT_W'(6)) ? h6_r : 8'd0;
    e7       = (cnt_r > ihex_pkg::CNT_W'(7)) ? h7_r : 8'd0;
    e8       = (cnt_r > ihex_pkg::CNT_W'(8)) ? h8_r : 8'd0;
    is_seg   = (e6 == ihex_pkg::SEG_TYPE);
    addr_sum = ihex_pkg::ADDR_SUM_W'({e4, e5}) + ihex_pkg::ADDR_SUM_W'(seg_base_r);
    q_push        = fin_r;
    q_desc.bad    = fin_bad_r;
    q_desc.cnt    = cnt_r;
    q_desc.bank   = bank_r;
    q_desc.adj_en = ~is_seg & seg_act_r;
    q_desc.adj    = addr_sum;
  end

  // Line control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= '0;
      hi_r       <= '0;
      pbad_r     <= 1'b0;
      ovf_r      <= 1'b0;
      cnt_r      <= '0;
      fin_r      <= 1'b0;
      fin_bad_r  <= 1'b0;
      seg_base_r <= '0;
      seg_act_r  <= 1'b0;
      bank_r     <= 1'b0;
    end else if (fin_r) begin
      fin_r  <= 1'b0;
      k_r    <= '0;
      hi_r   <= '0;
      pbad_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
      bank_r <= ~bank_r;
      if (!fin_bad_r && is_seg) begin
        seg_base_r <= {e7, e8, 4'd0};
        seg_act_r  <= 1'b1;
      end
    end else if (accept) begin
      if (k_r != ihex_pkg::CHAR_IDX_MAX) begin
        k_r <= k_r + ihex_pkg::CHAR_IDX_W'(1);
      end
      if (k_r != '0 && k_r[0]) begin
        hi_r   <= hx.ok ? hx.val : 4'd0;
        pbad_r <= ~hx.ok;
      end
      if (wr_any) begin
        if (in_cap) begin
          cnt_r <= ihex_pkg::CNT_W'(last_pos + ihex_pkg::POS_W'(1));
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (in_item.end_of_line) begin
        fin_r     <= 1'b1;
        fin_bad_r <= k_r[0] | ovf_r | (wr_any & ~in_cap);
      end
    end
  end

  // Row assembly register and header copies.
  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    if (do_wr) begin
      if (pos == ihex_pkg::POS_W'(4)) h4_r <= wr_val;
      if (pos == ihex_pkg::POS_W'(5)) h5_r <= wr_val;
      if (pos == ihex_pkg::POS_W'(6)) h6_r <= wr_val;
      if (pos == ihex_pkg::POS_W'(7)) h7_r <= wr_val;
      if (pos == ihex_pkg::POS_W'(8)) h8_r <= wr_val;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ihex_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Depends on ihex_pkg.
`default_nettype none

module ihex_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire ihex_pkg::desc_t             push_desc,
  input  wire logic                        pop,
  output      logic                        valid,
  output      ihex_pkg::desc_t             head,
  output      logic [ihex_pkg::QCNT_W-1:0] count
);

  ihex_pkg::desc_t             ent_r [ihex_pkg::QUEUE_DEPTH];
  logic [ihex_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [ihex_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [ihex_pkg::QCNT_W-1:0] count_r;
  logic                        do_pop;

  assign valid  = (count_r != '0);
  assign head   = ent_r[rd_ptr_r];
  assign count  = count_r;
  assign do_pop = pop & valid;

  // Pointers and occupancy; the front never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ihex_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + ihex_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + ihex_pkg::QCNT_W'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - ihex_pkg::QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ihex_back.sv
// Back end: walks each line descriptor, reads element rows from RAM and
// emits result rows through an output register. Depends on ihex_pkg.
`default_nettype none

module ihex_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire ihex_pkg::desc_t                 q_head,
  output      logic                            q_pop,
  output      logic                            ram_re,
  output      logic [ihex_pkg::RAM_ADDR_W-1:0] ram_raddr,
  input  wire ihex_pkg::row_t                  ram_rdata,
  output      logic                            out_empty,
  input  wire logic                            out_pop,
  output      ihex_pkg::out_item_t             out_item
);

  localparam logic ST_ISSUE = 1'b0;
  localparam logic ST_LOAD  = 1'b1;

  logic                            state_r;
  logic [ihex_pkg::ROW_ADDR_W-1:0] row_r;
  logic                            out_v_r;
  ihex_pkg::out_item_t             out_r;
  ihex_pkg::out_item_t             out_nxt;

  logic [ihex_pkg::CNT_W-1:0]      n;
  logic [ihex_pkg::CNT_W-1:0]      n_m1;
  logic                            is_last;
  logic [ihex_pkg::ROW_CNT_W-1:0]  row_cnt;
  ihex_pkg::row_t                  lanes;
  logic [ihex_pkg::CNT_W-1:0]      idx;
  logic                            issue;
  logic                            load;

  assign out_empty = ~out_v_r;
  assign out_item  = out_r;

  // A row read is issued only when the output register will be free next cycle.
  assign issue     = (state_r == ST_ISSUE) & q_valid & (~out_v_r | out_pop);
  assign load      = (state_r == ST_LOAD);
  assign ram_re    = issue;
  assign ram_raddr = {q_head.bank, row_r};
  assign q_pop     = load & (q_head.bad | is_last);

  // Row bookkeeping: a record has at least the seven header elements.
  always_comb begin
    n       = (q_head.cnt < ihex_pkg::CNT_W'(ihex_pkg::HEADER_ELEMS)) ?
              ihex_pkg::CNT_W'(ihex_pkg::HEADER_ELEMS) : q_head.cnt;
    n_m1    = n - ihex_pkg::CNT_W'(1);
    is_last = (row_r == n_m1[ihex_pkg::LANE_W +: ihex_pkg::ROW_ADDR_W]);
    if (is_last && n[ihex_pkg::LANE_W-1:0] != '0) begin
      row_cnt = ihex_pkg::ROW_CNT_W'(n[ihex_pkg::LANE_W-1:0]);
    end else begin
      row_cnt = ihex_pkg::ROW_CNT_W'(ihex_pkg::ROW_WIDTH);
    end
  end

  // Lane masking and the segment-adjusted address in the first row.
  always_comb begin
    idx = '0;
    for (int i = 0; i < ihex_pkg::ROW_WIDTH; i++) begin
      idx = ihex_pkg::CNT_W'({row_r, ihex_pkg::LANE_W'(i)});
      if (ihex_pkg::ROW_CNT_W'(i) < row_cnt && idx < q_head.cnt) begin
        lanes[i] = ram_rdata[i];
      end else begin
        lanes[i] = 8'd0;
      end
    end
    if (row_r == '0 && q_head.adj_en) begin
      lanes[2] = 8'd0;
      lanes[3] = 8'(q_head.adj[ihex_pkg::ADDR_SUM_W-1:16]);
      lanes[4] = q_head.adj[15:8];
      lanes[5] = q_head.adj[7:0];
    end
  end

  // Result row, or the single error result.
  always_comb begin
    if (q_head.bad) begin
      out_nxt            = '0;
      out_nxt.last_row   = 1'b1;
      out_nxt.bad_length = 1'b1;
    end else begin
      out_nxt.elem0      = lanes[0];
      out_nxt.elem1      = lanes[1];
      out_nxt.elem2      = lanes[2];
      out_nxt.elem3      = lanes[3];
      out_nxt.elem4      = lanes[4];
      out_nxt.elem5      = lanes[5];
      out_nxt.elem6      = lanes[6];
      out_nxt.elem7      = lanes[7];
      out_nxt.row_count  = row_cnt;
      out_nxt.last_row   = is_last;
      out_nxt.bad_length = 1'b0;
    end
  end

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ISSUE;
      row_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      case (state_r)
        ST_ISSUE: begin
          if (issue) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_r <= ST_ISSUE;
          if (q_head.bad || is_last) begin
            row_r <= '0;
          end else begin
            row_r <= row_r + ihex_pkg::ROW_ADDR_W'(1);
          end
        end
        default: begin
          state_r <= ST_ISSUE;
        end
      endcase
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/intel_hex_record_decoder.sv
// HEX record decoder top level: front end, descriptor queue, back end, element RAM.
// Characters are taken one per cycle within a line while the queue has room; the
// line end closes the line and queues its descriptor, and its rows then pass through
// the RAM read and the output register; each row is loaded before the next read.
// A new line may be received while up to one earlier line is still being emitted.
// Reset (rst_n low, synchronous) empties the queue and clears the segment base.
`default_nettype none

module intel_hex_record_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output      logic                in_full,
  input  wire ihex_pkg::in_item_t  in_item,
  output      logic                out_empty,
  input  wire logic                out_pop,
  output      ihex_pkg::out_item_t out_item
);

  logic                            q_push;
  ihex_pkg::desc_t                 q_desc;
  logic                            q_pop;
  logic                            q_valid;
  ihex_pkg::desc_t                 q_head;
  logic [ihex_pkg::QCNT_W-1:0]     q_count;
  ihex_pkg::ram_wr_t               ram_wr;
  logic                            ram_re;
  logic [ihex_pkg::RAM_ADDR_W-1:0] ram_raddr;
  ihex_pkg::row_t                  ram_rdata;

  // Character parsing and row packing.
  ihex_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_count (q_count),
    .q_push  (q_push),
    .q_desc  (q_desc),
    .ram_wr  (ram_wr)
  );

  // Finished lines waiting for emission.
  ihex_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head),
    .count     (q_count)
  );

  // Two banks of element rows, one per line in flight.
  ihex_ram #(
    .WIDTH (ihex_pkg::ROW_BITS),
    .DEPTH (ihex_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Row emission.
  ihex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_intel_hex_record_decoder.sv
// Self-checking testbench for intel_hex_record_decoder: feeds HEX record lines one
// character per beat and checks every emitted row against a line decoder kept in here.
// Depends on ihex_pkg for the port types and sizing constants, and on the RTL only.
module tb_intel_hex_record_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import ihex_pkg::*;

  localparam int STALL_LIMIT      = 4000;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 40;
  localparam int RANDOM_CHARS     = 280;
  localparam int SHOWN_MISMATCHES = 10;

  // Record types and the start code of a well-formed line.
  localparam logic [7:0] START_CODE     = 8'h3A;
  localparam logic [7:0] REC_DATA       = 8'h00;
  localparam logic [7:0] REC_START_LIN  = 8'h05;

  typedef logic [7:0] char_q_t [$];

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  // Line decoder state, mirrored from the block's behavior.
  logic [7:0]  line_elems [STORE_DEPTH];
  int unsigned n_elems;
  int unsigned char_idx;
  logic [3:0]  pend_nibble;
  bit          pend_bad;
  bit          line_ovf;
  logic [19:0] seg_base;
  bit          seg_on;

  out_item_t   expected_rows [$];
  int          mismatches;
  int          tx_max_gap;
  int          rx_max_gap;
  int          rx_hold;
  int unsigned idle_cycles = 0;
  string       row_fields [11] = '{"elem0", "elem1", "elem2", "elem3", "elem4", "elem5",
                                   "elem6", "elem7", "row_count", "last_row", "bad_length"};

  intel_hex_record_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  // Value of one ASCII hex digit, or -1 for any other character.
  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic void store_elem(int unsigned pos, logic [7:0] v);
    if (pos >= CAPACITY) begin
      line_ovf = 1'b1;
    end else begin
      line_elems[pos] = v;
      if (n_elems < pos + 1) n_elems = pos + 1;
    end
  endfunction

  // Elements that the line never reached read as zero.
  function automatic logic [7:0] elem_read(int unsigned i);
    return (i < n_elems && i < STORE_DEPTH) ? line_elems[i] : 8'h00;
  endfunction

  function automatic void clear_line();
    n_elems     = 0;
    char_idx    = 0;
    pend_nibble = '0;
    pend_bad    = 1'b0;
    line_ovf    = 1'b0;
  endfunction

  // Decode one accepted character; at end of line queue the rows it yields.
  function automatic void predict_char(in_item_t it);
    int unsigned k, n, row_base, cnt, idx, sum;
    int          d;
    logic [7:0]  b;
    logic [7:0]  hdr [2:5];
    logic [7:0]  v [8];
    out_item_t   row;
    k = char_idx;
    d = hex_digit(it.char_code);
    if (k == 0) begin
      store_elem(0, it.char_code);
    end else if (k % 2 == 1) begin
      pend_nibble = (d < 0) ? 4'h0 : d[3:0];
      pend_bad    = (d < 0);
    end else begin
      b = (pend_bad || d < 0) ? 8'h00 : {pend_nibble, d[3:0]};
      if (k / 2 == 1) begin
        store_elem(1, b);
        store_elem(2, 8'h00);
        store_elem(3, 8'h00);
      end else begin
        store_elem(k / 2 + 2, b);
      end
    end
    if (char_idx < CHAR_IDX_MAX) char_idx++;
    if (!it.end_of_line) return;

    // An odd count of characters after the first, or a dropped element, gives one error row.
    if (k % 2 == 1 || line_ovf) begin
      row = {64'h0, 4'd0, 1'b1, 1'b1};
      expected_rows.insert(expected_rows.size(), row);
      clear_line();
      return;
    end

    n = (n_elems < HEADER_ELEMS) ? HEADER_ELEMS : n_elems;
    for (int i = 2; i <= 5; i++) hdr[i] = elem_read(i);

    // A segment record loads the base; other records get it added to the address.
    if (elem_read(6) == SEG_TYPE) begin
      seg_base = {elem_read(7), elem_read(8), 4'h0};
      seg_on   = 1'b1;
    end else if (seg_on) begin
      sum = {hdr[4], hdr[5]} + seg_base;
      {hdr[2], hdr[3], hdr[4], hdr[5]} = sum;
    end

    for (row_base = 0; row_base < n; row_base += cnt) begin
      cnt = (n - row_base < ROW_WIDTH) ? n - row_base : ROW_WIDTH;
      for (int i = 0; i < 8; i++) begin
        idx = row_base + i;
        if (i >= cnt) v[i] = 8'h00;
        else if (idx >= 2 && idx <= 5) v[i] = hdr[idx];
        else v[i] = elem_read(idx);
      end
      row = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], 4'(cnt),
             row_base + cnt >= n, 1'b0};
      expected_rows.insert(expected_rows.size(), row);
    end
    clear_line();
  endfunction

  // Compare one popped row with the oldest expected one, field by field.
  function automatic void check_row(out_item_t got);
    out_item_t  want;
    logic [7:0] wv [11];
    logic [7:0] gv [11];
    bit         bad;
    if (expected_rows.size() == 0) begin
      if (mismatches < SHOWN_MISMATCHES) $display("row with nothing expected: %h", got);
      mismatches++;
      return;
    end
    want = expected_rows.pop_front();
    wv = '{want.elem0, want.elem1, want.elem2, want.elem3, want.elem4, want.elem5,
           want.elem6, want.elem7, want.row_count, want.last_row, want.bad_length};
    gv = '{got.elem0, got.elem1, got.elem2, got.elem3, got.elem4, got.elem5,
           got.elem6, got.elem7, got.row_count, got.last_row, got.bad_length};
    bad = 1'b0;
    for (int i = 0; i < 11; i++) begin
      if (gv[i] !== wv[i]) begin
        if (mismatches < SHOWN_MISMATCHES)
          $display("row field %s: expected %0h, got %0h", row_fields[i], wv[i], gv[i]);
        bad = 1'b1;
      end
    end
    if (bad) mismatches++;
  endfunction

  function automatic void put_hex(ref char_q_t q, input logic [7:0] b);
    logic [3:0] nib;
    bit         upper;
    upper = $urandom_range(1);
    for (int s = 1; s >= 0; s--) begin
      nib = b[s*4 +: 4];
      if (nib < 10) q.insert(q.size(), 8'("0") + nib);
      else q.insert(q.size(), (upper ? 8'("A") : 8'("a")) + nib - 8'd10);
    end
  endfunction

  // Well-formed record with random data bytes and a correct checksum.
  function automatic char_q_t build_record(logic [7:0] rtype, logic [15:0] addr, int n_data);
    char_q_t    q;
    logic [7:0] b, sum;
    q.insert(q.size(), START_CODE);
    sum = 8'(n_data) + addr[15:8] + addr[7:0] + rtype;
    put_hex(q, 8'(n_data));
    put_hex(q, addr[15:8]);
    put_hex(q, addr[7:0]);
    put_hex(q, rtype);
    repeat (n_data) begin
      b = $urandom;
      sum += b;
      put_hex(q, b);
    end
    put_hex(q, 8'h00 - sum);
    return q;
  endfunction

  // Offer one character after a random gap and hold it until the block takes the beat.
  task automatic send_char(logic [7:0] c, logic eol);
    int gap;
    gap = $urandom_range(tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= {c, eol};
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    predict_char(in_item);
  endtask

  task automatic send_line(char_q_t chars);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic send_text(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    send_line(q);
  endtask

  // Lines too short to fill the header, odd lengths and odd start codes.
  task automatic test_short_and_odd();
    char_q_t q;
    tx_max_gap = 9;
    rx_max_gap = 9;
    send_text(":");
    send_text(":0");
    q = '{8'hFF, "z", "z"};
    send_line(q);
  endtask

  // Upper and lower case digits, and pairs with a bad first or second digit.
  task automatic test_hex_digits();
    send_text(":1aF9G00/");
  endtask

  // Segment base load, address carry past 16 bits, and a base with no data bytes.
  task automatic test_segment_base();
    send_text(":02000002F00F");
    send_text(":01FFFF00ab");
    send_text(":00000002");
    send_text(":0000000100");
  endtask

  // The receiver stops for a long stretch while lines keep coming, so the input stalls.
  task automatic test_backpressure();
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_hold    = HOLD_CYCLES;
    repeat (6) send_line(build_record(REC_DATA, $urandom, $urandom_range(12)));
  endtask

  // Mostly well-formed records of random type and size, with corrupted lines and noise.
  task automatic test_random_records();
    int         sent, kind, n_data, cut;
    logic [7:0] rtype;
    char_q_t    line;
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      tx_max_gap = $urandom_range(1) ? 9 : 0;
      rx_max_gap = $urandom_range(1) ? 9 : 0;
      kind = $urandom_range(9);
      if (kind <= 8) begin
        n_data = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(16);
        if ($urandom_range(3) == 0) rtype = SEG_TYPE;
        else if ($urandom_range(15) == 0) rtype = $urandom;
        else rtype = 8'($urandom_range(REC_START_LIN));
        line = build_record(rtype, $urandom, n_data);
        // Some lines get a stray character or lose their tail.
        if (kind == 7) line[$urandom_range(line.size() - 1)] = $urandom;
        if (kind == 8) begin
          cut = $urandom_range(line.size() - 1);
          repeat (cut) void'(line.pop_back());
        end
      end else begin
        line = {};
        repeat ($urandom_range(15, 1)) line.insert(line.size(), 8'($urandom));
      end
      send_line(line);
      sent += line.size();
    end
  endtask

  // Result side: random gaps, an occasional long hold, and a check on every beat.
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      gap = (rx_hold > 0) ? rx_hold : $urandom_range(rx_max_gap);
      rx_hold = 0;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      check_row(out_item);
    end
  end

  // Cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_item    = '0;
    out_pop    = 1'b0;
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_hold    = 0;
    mismatches = 0;
    seg_base   = '0;
    seg_on     = 1'b0;
    clear_line();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_and_odd();
    test_hex_digits();
    test_segment_base();
    test_backpressure();
    test_random_records();

    @(negedge clk);
    in_push <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_ram.sv
hw/rtl/ihex_front.sv
hw/rtl/ihex_queue.sv
hw/rtl/ihex_back.sv
hw/rtl/intel_hex_record_decoder.sv
tb/sv/tb_intel_hex_record_decoder.sv
